// ===== hdl/mba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mba_pkg: shared types and constants for the block averager
// Channel map, group layout and field widths of the multichannel averager.
// ----------------------------------------------------------------------------
package mba_pkg;

  localparam int NumChannels = 17;
  localparam int ChW         = 5;
  localparam int SampleW     = 10;
  localparam int CfgW        = 9;
  localparam int SampleMax   = 1023;

  typedef logic [ChW-1:0]     chan_t;
  typedef logic [SampleW-1:0] sample_t;
  typedef logic [1:0]         group_t;

  localparam chan_t LastChannel = chan_t'(NumChannels - 1);

  // Group of a valid channel: 0-7, 8-11, 12-15, 16
  function automatic group_t group_of(input chan_t ch);
    group_t g;
    if (ch < chan_t'(8)) begin
      g = 2'd0;
    end else if (ch < chan_t'(12)) begin
      g = 2'd1;
    end else if (ch < chan_t'(16)) begin
      g = 2'd2;
    end else begin
      g = 2'd3;
    end
    return g;
  endfunction

  // First channel of a group
  function automatic chan_t group_base(input group_t g);
    chan_t b;
    unique case (g)
      2'd0:    b = chan_t'(0);
      2'd1:    b = chan_t'(8);
      2'd2:    b = chan_t'(12);
      default: b = chan_t'(16);
    endcase
    return b;
  endfunction

  // Closing channel of a group
  function automatic chan_t group_end(input group_t g);
    chan_t e;
    unique case (g)
      2'd0:    e = chan_t'(7);
      2'd1:    e = chan_t'(11);
      2'd2:    e = chan_t'(15);
      default: e = chan_t'(16);
    endcase
    return e;
  endfunction

endpackage

// ===== hdl/multichannel_block_averager_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_block_averager_top: block-averaging decimator for 17 channels
// Sums samples per channel and emits the truncated mean of each channel of a
// group once the group has completed the configured number of passes.
// ----------------------------------------------------------------------------
// Each sample word is handled as a sum read, then a sum write, before the block
// is ready again. When a word closes the last pass of a group, the block then
// emits one mean per channel of the group; each mean goes through a read, a
// divider load, SUM_W restoring divide steps and an output word held until
// taken, where SUM_W = clog2(1023 * MAX_AVERAGE + 1) is 18 at the default.
// No sample word is taken until the last mean of the group is out. The
// sums live in a 17-entry memory with one read and one write port and a
// valid bit per entry, so reset needs no clearing pass. One serial divider
// serves all channels. Channels above 16 are dropped without any result.
// ----------------------------------------------------------------------------
module multichannel_block_averager_top #(
  parameter int MAX_AVERAGE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        average_count_we_i,
  input  logic [8:0]  average_count_i,
  // sample words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [4:0]  channel_i,
  input  logic [9:0]  sample_i,
  // mean words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  out_channel_o,
  output logic [9:0]  mean_o,
  output logic        group_last_o
);

  localparam int SumLimit = mba_pkg::SampleMax * MAX_AVERAGE;
  localparam int SumW     = $clog2(SumLimit + 1);
  localparam int PassW    = $clog2(MAX_AVERAGE + 1);
  localparam int CmpW     = (PassW > mba_pkg::CfgW) ? PassW : mba_pkg::CfgW;
  localparam int StepW    = $clog2(SumW + 1);

  localparam logic [SumW-1:0]  SumLimitC = SumW'(SumLimit);
  localparam logic [PassW-1:0] MaxPassC  = PassW'(MAX_AVERAGE);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_INIT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic [mba_pkg::CfgW-1:0]      avg_q;
  logic [PassW-1:0]              pass_q [4];
  logic [PassW-1:0]              pass_d [4];
  logic [mba_pkg::NumChannels-1:0] vld_q, vld_d;

  mba_pkg::chan_t                ch_q, ch_d;
  mba_pkg::sample_t              smp_q, smp_d;
  mba_pkg::chan_t                idx_q, idx_d;
  logic [PassW-1:0]              div_q, div_d;
  logic [PassW-1:0]              rem_q, rem_d;
  logic [SumW-1:0]               quo_q, quo_d;
  logic [StepW-1:0]              step_q, step_d;
  logic [mba_pkg::SampleW-1:0]   mean_q, mean_d;
  logic                          glast_q, glast_d;

  // sum memory with registered read
  logic [SumW-1:0]               sum_mem [mba_pkg::NumChannels];
  logic [SumW-1:0]               rd_data_q;
  logic                          rd_vld_q;
  mba_pkg::chan_t                rd_addr;
  logic                          wr_en;
  logic [SumW-1:0]               wr_data;

  // datapath helpers
  mba_pkg::group_t               grp;
  logic [SumW-1:0]               cur_sum;
  logic [SumW:0]                 acc_ext;
  logic [PassW:0]                pass_inc;
  logic [PassW-1:0]              passes;
  logic [CmpW-1:0]               eff_cnt;
  logic [PassW:0]                rem_sh;
  logic                          q_bit;
  logic [SumW-1:0]               quo_next;

  // memory read address: incoming channel when idle, burst index otherwise
  always_comb begin
    rd_addr = idx_q;
    if (state_q == S_IDLE) begin
      rd_addr = (channel_i <= mba_pkg::LastChannel) ? channel_i : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sum_mem[ch_q] <= wr_data;
    end
    rd_data_q <= sum_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  // an entry without its valid bit reads as zero
  assign cur_sum = rd_vld_q ? rd_data_q : '0;
  assign grp     = mba_pkg::group_of(ch_q);

  // saturating accumulate
  always_comb begin
    acc_ext = {1'b0, cur_sum} + (SumW + 1)'(smp_q);
    wr_data = (acc_ext > {1'b0, SumLimitC}) ? SumLimitC : acc_ext[SumW-1:0];
  end

  // pass count advance, saturated
  always_comb begin
    pass_inc = {1'b0, pass_q[grp]} + (PassW + 1)'(1);
    passes   = (pass_inc > {1'b0, MaxPassC}) ? MaxPassC : pass_inc[PassW-1:0];
  end

  // effective average count: zero acts as one, capped at MAX_AVERAGE
  always_comb begin
    priority if (avg_q == '0) begin
      eff_cnt = CmpW'(1);
    end else if (CmpW'(avg_q) > CmpW'(MaxPassC)) begin
      eff_cnt = CmpW'(MaxPassC);
    end else begin
      eff_cnt = CmpW'(avg_q);
    end
  end

  // restoring divide step: one quotient bit per cycle
  always_comb begin
    rem_sh   = {rem_q, quo_q[SumW-1]};
    q_bit    = (rem_sh >= {1'b0, div_q});
    quo_next = {quo_q[SumW-2:0], q_bit};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    vld_d   = vld_q;
    ch_d    = ch_q;
    smp_d   = smp_q;
    idx_d   = idx_q;
    div_d   = div_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    step_d  = step_q;
    mean_d  = mean_q;
    glast_d = glast_q;
    wr_en   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && (channel_i <= mba_pkg::LastChannel)) begin
          ch_d    = channel_i;
          smp_d   = sample_i;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        wr_en       = 1'b1;
        vld_d[ch_q] = 1'b1;
        state_d     = S_IDLE;
        if (ch_q == mba_pkg::group_end(grp)) begin
          if (CmpW'(passes) >= eff_cnt) begin
            pass_d[grp] = '0;
            div_d       = passes;
            idx_d       = mba_pkg::group_base(grp);
            state_d     = S_LOAD;
          end else begin
            pass_d[grp] = passes;
          end
        end
      end
      S_LOAD: begin
        state_d = S_INIT;
      end
      S_INIT: begin
        quo_d        = cur_sum;
        rem_d        = '0;
        step_d       = StepW'(SumW);
        vld_d[idx_q] = 1'b0;
        state_d      = S_DIV;
      end
      S_DIV: begin
        quo_d  = quo_next;
        rem_d  = q_bit ? PassW'(rem_sh - {1'b0, div_q}) : rem_sh[PassW-1:0];
        step_d = step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          mean_d  = (quo_next > SumW'(mba_pkg::SampleMax))
                    ? mba_pkg::sample_t'(mba_pkg::SampleMax)
                    : quo_next[mba_pkg::SampleW-1:0];
          glast_d = (idx_q == mba_pkg::group_end(grp));
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          if (glast_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + mba_pkg::chan_t'(1);
            state_d = S_LOAD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      avg_q   <= mba_pkg::CfgW'(1);
      vld_q   <= '0;
      for (int g = 0; g < 4; g++) begin
        pass_q[g] <= '0;
      end
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      pass_q  <= pass_d;
      if (average_count_we_i) begin
        avg_q <= average_count_i;
      end
    end
  end

  // payload and divider registers
  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    smp_q   <= smp_d;
    idx_q   <= idx_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    step_q  <= step_d;
    mean_q  <= mean_d;
    glast_q <= glast_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign out_channel_o = idx_q;
  assign mean_o        = mean_q;
  assign group_last_o  = glast_q;

endmodule

// ===== dv/multichannel_block_averager_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_block_averager_checker: scoreboard for the block averager
// Watches the config port and both word channels, keeps its own per-channel
// sums and per-group pass counts, predicts every mean word and compares the
// mean words leaving the block in order, field by field.
// ----------------------------------------------------------------------------
module multichannel_block_averager_checker #(
  parameter int MAX_AVERAGE = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             average_count_we_i,
  input  logic [8:0]       average_count_i,
  // sample words
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  mba_pkg::chan_t   channel_i,
  input  mba_pkg::sample_t sample_i,
  // mean words
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  mba_pkg::chan_t   out_channel_i,
  input  mba_pkg::sample_t mean_i,
  input  logic             group_last_i,
  // status for the test top
  output int               fail_count_o,
  output int               pending_o,
  output int               means_checked_o
);

  import mba_pkg::*;

  localparam int unsigned SumLimit = SampleMax * MAX_AVERAGE;

  typedef struct packed {
    chan_t   chan;
    sample_t mean;
    logic    last;
  } mean_word_t;

  logic [8:0]  avg_reg;
  int unsigned chan_sum [NumChannels];
  int unsigned pass_cnt [4];
  mean_word_t  pending_means [$];
  mean_word_t  exp_w;
  int          fails;
  int          checked;

  // Add one sample to its channel; on a closing pass, queue the group's means
  function automatic void accumulate_sample(input chan_t ch, input sample_t smp);
    int unsigned sum, passes, eff, q, first, last, g;
    mean_word_t  w;
    if (ch > LastChannel) return;
    sum = chan_sum[ch] + smp;
    chan_sum[ch] = (sum > SumLimit) ? SumLimit : sum;
    // group layout: 0-7, 8-11, 12-15, 16
    if (ch < 8) begin
      g = 0; first = 0; last = 7;
    end else if (ch < 12) begin
      g = 1; first = 8; last = 11;
    end else if (ch < 16) begin
      g = 2; first = 12; last = 15;
    end else begin
      g = 3; first = 16; last = 16;
    end
    if (ch != last) return;
    passes = pass_cnt[g] + 1;
    if (passes > MAX_AVERAGE) passes = MAX_AVERAGE;
    pass_cnt[g] = passes;
    // zero means one, anything above the maximum saturates
    eff = (avg_reg == 0) ? 1 : ((avg_reg > MAX_AVERAGE) ? MAX_AVERAGE : avg_reg);
    if (passes < eff) return;
    for (int c = first; c <= last; c++) begin
      q = chan_sum[c] / passes;
      w.chan = chan_t'(c);
      w.mean = (q > SampleMax) ? sample_t'(SampleMax) : sample_t'(q);
      w.last = (c == last);
      pending_means.push_back(w);
      chan_sum[c] = 0;
    end
    pass_cnt[g] = 0;
  endfunction

  // Compare departing mean words, then track config and arriving samples
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_reg = 9'd1;
      for (int i = 0; i < NumChannels; i++) chan_sum[i] = 0;
      for (int i = 0; i < 4; i++) pass_cnt[i] = 0;
      pending_means.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_means.size() == 0) begin
          $error("unexpected mean word: out_channel %0d, mean %0d, group_last %0d",
                 out_channel_i, mean_i, group_last_i);
          fails++;
        end else begin
          exp_w = pending_means.pop_front();
          checked++;
          if (out_channel_i !== exp_w.chan) begin
            $error("out_channel: expected %0d, actual %0d", exp_w.chan, out_channel_i);
            fails++;
          end
          if (mean_i !== exp_w.mean) begin
            $error("mean: expected %0d, actual %0d", exp_w.mean, mean_i);
            fails++;
          end
          if (group_last_i !== exp_w.last) begin
            $error("group_last: expected %0d, actual %0d", exp_w.last, group_last_i);
            fails++;
          end
        end
      end
      if (average_count_we_i) avg_reg = average_count_i;
      if (in_valid_i && in_ready_i) accumulate_sample(channel_i, sample_i);
    end
    fail_count_o    <= fails;
    pending_o       <= pending_means.size();
    means_checked_o <= checked;
  end

endmodule

// ===== dv/multichannel_block_averager_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_block_averager_top_test: test top for the block averager
// Drives sample words and average-count writes, stalls the mean channel on
// its own pattern, and reports the verdict from the checker's failure count.
// Directed words cover the field extremes, dropped channels, zero and
// saturating counts and a count lowered mid-block; random phases follow.
// ----------------------------------------------------------------------------
module multichannel_block_averager_top_test;

  import mba_pkg::*;

  localparam int MaxAverage = 256;
  localparam int IdleCycles = 8;        // block settle time before a config write
  localparam int TailCycles = 400;      // covers a full burst of stray means
  localparam int TimeoutNs  = 10_000_000;

  typedef enum logic [1:0] {
    RxAlways,
    RxLight,
    RxHeavy
  } rx_mode_e;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       average_count_we = 1'b0;
  logic [8:0] average_count    = '0;
  logic       in_valid         = 1'b0;
  logic       in_ready;
  chan_t      channel          = '0;
  sample_t    sample           = '0;
  logic       out_valid;
  logic       out_ready        = 1'b0;
  chan_t      out_channel;
  sample_t    mean;
  logic       group_last;

  int         fail_count;
  int         pending;
  int         means_checked;

  rx_mode_e   rx_mode    = RxAlways;
  int         mode_left  = 0;
  int         stall_left = 0;

  logic       pace_gaps  = 1'b1;
  int         burst_left = 0;
  int         words_sent = 0;
  int         words_dropped = 0;
  int         n_writes   = 0;

  multichannel_block_averager_top #(
    .MAX_AVERAGE(MaxAverage)
  ) u_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .average_count_we_i (average_count_we),
    .average_count_i    (average_count),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .channel_i          (channel),
    .sample_i           (sample),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .out_channel_o      (out_channel),
    .mean_o             (mean),
    .group_last_o       (group_last)
  );

  multichannel_block_averager_checker #(
    .MAX_AVERAGE(MaxAverage)
  ) u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .average_count_we_i (average_count_we),
    .average_count_i    (average_count),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .channel_i          (channel),
    .sample_i           (sample),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .out_channel_i      (out_channel),
    .mean_i             (mean),
    .group_last_i       (group_last),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .means_checked_o    (means_checked)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mean receiver: switches between no stalls, short stalls and long stalls
  always @(posedge clk) begin
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_e'($urandom_range(0, 2));
      mode_left <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      case (rx_mode)
        RxLight: if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 3);
        RxHeavy: if ($urandom_range(0, 1) == 0) stall_left <= $urandom_range(1, 20);
        default: ;
      endcase
    end
  end

  // Sample with the extremes weighted up
  function automatic sample_t rand_sample();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return sample_t'(SampleMax);
    return sample_t'($urandom_range(0, SampleMax));
  endfunction

  // Send one sample word; bursts of random length, with random gaps between when pace_gaps is set
  task automatic send_word(input chan_t ch, input sample_t smp);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (pace_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    channel  <= ch;
    sample   <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (ch > LastChannel) words_dropped++;
    else words_sent++;
  endtask

  // Hold off the sender until every predicted mean word has been taken
  task automatic drain_means();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IdleCycles) @(posedge clk);
  endtask

  task automatic set_average(input logic [8:0] value);
    drain_means();
    average_count_we <= 1'b1;
    average_count    <= value;
    @(posedge clk);
    average_count_we <= 1'b0;
    n_writes++;
  endtask

  // Mostly whole passes of a group, some stray channels, some dropped words
  task automatic run_mixed(input int n_words);
    int start, kind, first, size;
    start = words_sent;
    while (words_sent - start < n_words) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) begin
        case ($urandom_range(0, 3))
          0:       begin first = 0;  size = 8; end
          1:       begin first = 8;  size = 4; end
          2:       begin first = 12; size = 4; end
          default: begin first = 16; size = 1; end
        endcase
        for (int k = 0; k < size; k++) send_word(chan_t'(first + k), rand_sample());
      end else if (kind < 18) begin
        repeat ($urandom_range(1, 4)) send_word(chan_t'($urandom_range(0, 16)), rand_sample());
      end else if (kind == 18) begin
        send_word(chan_t'($urandom_range(17, 31)), rand_sample());
      end else begin
        drain_means();
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset count of one: single-channel group, then a small group at extremes
    send_word(5'd16, 10'd1023);
    send_word(5'd8, 10'd0);
    send_word(5'd9, 10'd1023);
    send_word(5'd10, 10'd512);
    send_word(5'd11, 10'd1);
    // channels above 16 are dropped
    send_word(5'd17, 10'd1023);
    send_word(5'd31, 10'd0);
    // full eight-channel group
    for (int k = 0; k < 8; k++) send_word(chan_t'(k), sample_t'(k * 146));
    // zero acts as one
    set_average(9'd0);
    send_word(5'd16, 10'd0);
    // two passes under way, one stray word in group 2
    set_average(9'd3);
    send_word(5'd16, 10'd1000);
    send_word(5'd16, 10'd1001);
    send_word(5'd12, 10'd700);
    // above the maximum: saturates, so no mean yet
    set_average(9'd511);
    send_word(5'd16, 10'd1023);
    // lowered mid-block: next pass emits, divided by the real pass count
    set_average(9'd1);
    send_word(5'd16, 10'd7);
    // out of order with a repeat; channel 12 mean clamps
    send_word(5'd13, 10'd3);
    send_word(5'd14, 10'd1023);
    send_word(5'd12, 10'd1023);
    send_word(5'd15, 10'd0);

    // random phases
    set_average(9'd1);
    pace_gaps = ($urandom_range(0, 1) == 1);
    run_mixed(20);

    set_average(9'($urandom_range(2, 5)));
    pace_gaps = 1'b0;
    run_mixed(20);

    // largest count on the single-channel group
    set_average(9'd256);
    pace_gaps = 1'b1;
    repeat (256) send_word(LastChannel, rand_sample());

    // one channel piled past its sum limit within a single pass
    set_average(9'd0);
    pace_gaps = ($urandom_range(0, 1) == 1);
    repeat (258) send_word(5'd12, sample_t'($urandom_range(1020, SampleMax)));
    for (int c = 13; c <= 15; c++) send_word(chan_t'(c), rand_sample());

    drain_means();
    repeat (TailCycles) @(posedge clk);

    $display("Sent %0d sample words (plus %0d dropped channels), checked %0d mean words,",
             words_sent, words_dropped, means_checked);
    $display("over %0d average-count writes incl. 0, 256, 511 and a mid-block decrease.",
             n_writes);
    if (fail_count == 0) begin
      $display("[multichannel_block_averager_top] OK");
    end else begin
      $display("[multichannel_block_averager_top] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TimeoutNs);
    $display("[multichannel_block_averager_top] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/mba_pkg.sv
hdl/multichannel_block_averager_top.sv
dv/multichannel_block_averager_checker.sv
dv/multichannel_block_averager_top_test.sv
